>>> hw/rtl/event_vector_aggregator_top_macros.svh
// assertion macros used by the aggregator top level
`ifndef EVENT_VECTOR_AGGREGATOR_TOP_MACROS_SVH
`define EVENT_VECTOR_AGGREGATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define EVA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define EVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/evagg_pkg.sv
// shared types, codes and constants of the event vector aggregator
package evagg_pkg;

	localparam int MAX_VECTOR = 32;
	localparam int ADDR_W     = $clog2(MAX_VECTOR);
	localparam int CNT_W      = 6;
	localparam int AGE_W      = 32;
	localparam int WORD_W     = 64;

	localparam logic [1:0] REQ_OBJ   = 2'd0;
	localparam logic [1:0] REQ_FLUSH = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [1:0] CAUSE_FULL     = 2'd0;
	localparam logic [1:0] CAUSE_MARK     = 2'd1;
	localparam logic [1:0] CAUSE_TIMEOUT  = 2'd2;
	localparam logic [1:0] CAUSE_FALLBACK = 2'd3;

	localparam logic KIND_VEC    = 1'b0;
	localparam logic KIND_SINGLE = 1'b1;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_VSIZE    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_VMETA    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_FALLMETA = 2'd3;

	localparam logic [CNT_W-1:0] VSIZE_RST   = 6'd32;
	localparam logic [AGE_W-1:0] TIMEOUT_RST = 32'd1000;

	typedef struct packed {
		logic [CNT_W-1:0]  vector_size;
		logic [AGE_W-1:0]  timeout_ticks;
		logic [WORD_W-1:0] vector_meta;
		logic [WORD_W-1:0] fallback_meta;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [WORD_W-1:0] object_value;
		logic              start_vector;
		logic              end_vector;
		logic              call_end;
		logic              buffer_free;
	} in_item_t;

	typedef struct packed {
		logic              event_kind;
		logic [WORD_W-1:0] evt_meta;
		logic [WORD_W-1:0] element_value;
		logic [CNT_W-1:0]  element_count;
		logic [1:0]        flush_cause;
		logic              last;
	} out_rec_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic       pop;
	} oq_stat_t;

endpackage

>>> hw/rtl/evagg_cfg.sv
// apb register file for size, timeout and metadata words
module evagg_cfg import evagg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [CNT_W-1:0]     vsize_q;
	logic [AGE_W-1:0]     timeout_q;
	logic [WORD_W-1:0]    vmeta_q;
	logic [WORD_W-1:0]    fmeta_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:3];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsize_q   <= VSIZE_RST;
			timeout_q <= TIMEOUT_RST;
			vmeta_q   <= '0;
			fmeta_q   <= '0;
		end else if (wr) begin
			case (idx)
				REG_VSIZE:    vsize_q   <= pwdata[CNT_W-1:0];
				REG_TIMEOUT:  timeout_q <= pwdata[AGE_W-1:0];
				REG_VMETA:    vmeta_q   <= pwdata;
				REG_FALLMETA: fmeta_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_VSIZE:    prdata = {{(64-CNT_W){1'b0}}, vsize_q};
			REG_TIMEOUT:  prdata = {{(64-AGE_W){1'b0}}, timeout_q};
			REG_VMETA:    prdata = vmeta_q;
			REG_FALLMETA: prdata = fmeta_q;
			default:      prdata = '0;
		endcase
	end

	assign cfg.vector_size   = vsize_q;
	assign cfg.timeout_ticks = timeout_q;
	assign cfg.vector_meta   = vmeta_q;
	assign cfg.fallback_meta = fmeta_q;

endmodule

>>> hw/rtl/evagg_ctrl.sv
// sequencer with the vector store: fill, age, drain and fallback
module evagg_ctrl import evagg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  cfg_t     cfg,
	input  oq_stat_t oq_stat,
	output logic     push_valid,
	output out_rec_t push_rec
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRE   = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_END   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VECTOR);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	logic [WORD_W-1:0] mem [MAX_VECTOR];

	logic [2:0]        state_q, state_d;
	logic [2:0]        ret_q, ret_d;
	logic [1:0]        cause_q, cause_d;
	logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]  dcnt_q, dcnt_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic              open_q, open_d;
	logic [AGE_W-1:0]  age_q, age_d;
	in_item_t          item_q;

	logic              valid_s1;
	logic              from_mem_s1;
	out_rec_t          rec_s1;
	logic [WORD_W-1:0] rd_data_s1;

	logic              issue, issue_mem;
	out_rec_t          issue_rec;
	logic              wr_en;
	logic [CNT_W-1:0]  eff_size, add_base, fill_new;
	logic              add_room;
	logic [AGE_W-1:0]  age_inc;
	logic              can_issue;
	logic              drain_last;

	assign in_ready = (state_q == ST_IDLE);

	// slot check counts the read in flight toward the output queue
	assign can_issue = ((3'(oq_stat.cnt) + 3'(valid_s1)) < 3'd2) || oq_stat.pop;

	always_comb begin
		if (cfg.vector_size == '0)
			eff_size = ONE_CNT;
		else if (cfg.vector_size > MAX_CNT)
			eff_size = MAX_CNT;
		else
			eff_size = cfg.vector_size;
	end

	assign age_inc    = (age_q == '1) ? age_q : age_q + AGE_W'(1);
	assign add_base   = open_q ? fill_q : '0;
	assign add_room   = add_base < MAX_CNT;
	assign fill_new   = add_room ? add_base + ONE_CNT : add_base;
	assign drain_last = (rd_idx_q + ONE_CNT) == dcnt_q;

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		cause_d   = cause_q;
		rd_idx_d  = rd_idx_q;
		dcnt_d    = dcnt_q;
		fill_d    = fill_q;
		open_d    = open_q;
		age_d     = age_q;
		issue     = 1'b0;
		issue_mem = 1'b0;
		issue_rec = '0;
		wr_en     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_PRE;
			end
			ST_PRE: begin
				state_d = ST_IDLE;
				rd_idx_d = '0;
				dcnt_d = fill_q;
				case (item_q.req_type)
					REQ_OBJ: begin
						state_d = ST_ADD;
						if (item_q.start_vector && open_q) begin
							state_d = ST_DRAIN;
							cause_d = CAUSE_MARK;
							ret_d = ST_ADD;
						end
					end
					REQ_FLUSH: begin
						if (open_q) begin
							state_d = ST_DRAIN;
							cause_d = CAUSE_MARK;
							ret_d = ST_IDLE;
						end
					end
					REQ_TICK: begin
						if (open_q) begin
							age_d = age_inc;
							if (age_inc >= cfg.timeout_ticks) begin
								state_d = ST_DRAIN;
								cause_d = CAUSE_TIMEOUT;
								ret_d = ST_IDLE;
							end
						end
					end
					default: ;
				endcase
			end
			ST_ADD: begin
				if (open_q || item_q.buffer_free) begin
					open_d = 1'b1;
					wr_en = add_room;
					fill_d = fill_new;
					state_d = ST_END;
					if (fill_new >= eff_size) begin
						state_d = ST_DRAIN;
						rd_idx_d = '0;
						dcnt_d = fill_new;
						cause_d = CAUSE_FULL;
						ret_d = ST_END;
					end
				end else if (can_issue) begin
					issue = 1'b1;
					issue_rec.event_kind    = KIND_SINGLE;
					issue_rec.evt_meta      = cfg.fallback_meta;
					issue_rec.element_value = item_q.object_value;
					issue_rec.element_count = ONE_CNT;
					issue_rec.flush_cause   = CAUSE_FALLBACK;
					issue_rec.last          = 1'b1;
					state_d = ST_END;
				end
			end
			ST_END: begin
				state_d = ST_IDLE;
				if (item_q.call_end) begin
					if (item_q.end_vector && open_q) begin
						state_d = ST_DRAIN;
						rd_idx_d = '0;
						dcnt_d = fill_q;
						cause_d = CAUSE_MARK;
						ret_d = ST_IDLE;
					end else if (open_q) begin
						age_d = '0;
					end
				end
			end
			ST_DRAIN: begin
				if (can_issue) begin
					issue = 1'b1;
					issue_mem = 1'b1;
					issue_rec.event_kind    = KIND_VEC;
					issue_rec.evt_meta      = cfg.vector_meta;
					issue_rec.element_count = dcnt_q;
					issue_rec.flush_cause   = cause_q;
					issue_rec.last          = drain_last;
					rd_idx_d = rd_idx_q + ONE_CNT;
					if (drain_last) begin
						open_d = 1'b0;
						fill_d = '0;
						age_d = '0;
						state_d = ret_q;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			cause_q  <= CAUSE_FULL;
			rd_idx_q <= '0;
			dcnt_q   <= '0;
			fill_q   <= '0;
			open_q   <= 1'b0;
			age_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			cause_q  <= cause_d;
			rd_idx_q <= rd_idx_d;
			dcnt_q   <= dcnt_d;
			fill_q   <= fill_d;
			open_q   <= open_d;
			age_q    <= age_d;
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_q <= in_item;
		if (issue) begin
			rec_s1      <= issue_rec;
			from_mem_s1 <= issue_mem;
		end
	end

	// vector store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[add_base[ADDR_W-1:0]] <= item_q.object_value;
		if (issue_mem)
			rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	always_comb begin
		push_rec = rec_s1;
		if (from_mem_s1)
			push_rec.element_value = rd_data_s1;
	end

	assign push_valid = valid_s1;

endmodule

>>> hw/rtl/evagg_outq.sv
// two-entry result queue in front of the master stream port
module evagg_outq import evagg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	input  out_rec_t push_rec,
	output oq_stat_t oq_stat,
	output logic     out_valid,
	input  logic     out_ready,
	output out_rec_t out_rec
);

	out_rec_t   ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_rec   = ent_q[rd_ptr_q];

	assign oq_stat.cnt = cnt_q;
	assign oq_stat.pop = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_valid)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push_valid) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid)
			ent_q[wr_ptr_q] <= push_rec;
	end

endmodule

>>> hw/rtl/event_vector_aggregator_top.sv
// top level of the event vector aggregator
//
//  port group  dir  beat contents
//  s_*         in   tuser req_type, tlast call_end, tdata object/marks/buffer_free
//  m_*         out  tuser event_kind, tlast last, tdata meta/value/count/cause
//  apb         in   vector_size, timeout_ticks, vector_meta, fallback_meta
//
// an object passes accept, decide, add and close; flush and tick pass only accept and decide
// each drained vector element is read from the store through a registered read port
// drains run at one beat a cycle through a two-entry result queue; m_tready low stalls them
// a new beat is taken once the sequencer is idle, even with results still queued
// reset clears all control state; the vector store needs no clearing pass
module event_vector_aggregator_top import evagg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // object_value, start_vector, end_vector, buffer_free, pad
	input  logic [1:0]   s_tuser,   // req_type
	input  logic         s_tlast,   // call_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // event meta, element_value, element_count, flush_cause
	output logic         m_tuser,   // event_kind
	output logic         m_tlast,   // last
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	cfg_t     cfg;
	in_item_t in_item;
	oq_stat_t oq_stat;
	logic     push_valid;
	out_rec_t push_rec;
	out_rec_t out_rec;

	assign in_item.req_type     = s_tuser;
	assign in_item.object_value = s_tdata[63:0];
	assign in_item.start_vector = s_tdata[64];
	assign in_item.end_vector   = s_tdata[65];
	assign in_item.buffer_free  = s_tdata[66];
	assign in_item.call_end     = s_tlast;

	evagg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	evagg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.cfg        (cfg),
		.oq_stat    (oq_stat),
		.push_valid (push_valid),
		.push_rec   (push_rec)
	);

	evagg_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.oq_stat    (oq_stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_rec    (out_rec)
	);

	assign m_tdata = {out_rec.flush_cause, out_rec.element_count,
		out_rec.element_value, out_rec.evt_meta};
	assign m_tuser = out_rec.event_kind;
	assign m_tlast = out_rec.last;

`include "event_vector_aggregator_top_macros.svh"

	`EVA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`EVA_ASSERT_NOW(a_queue_bound, 1'b1, oq_stat.cnt != 2'd3, "result queue overflow")
	`EVA_ASSERT_NOW(a_push_room, push_valid && (oq_stat.cnt == 2'd2), oq_stat.pop, "push into full queue")

endmodule

>>> tb/tb_event_vector_aggregator_top.sv
// self-checking testbench of the event vector aggregator: stream, apb and batching behavior
`timescale 1ns / 100ps

module tb_event_vector_aggregator_top import evagg_pkg::*;;

	localparam int CLK_HALF    = 2;
	localparam int SETTLE_CYC  = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_MAX  = 10;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;

	event_vector_aggregator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// predictor state and shadow registers
	logic [WORD_W-1:0] agg_store [MAX_VECTOR];
	int unsigned       agg_fill;
	bit                agg_open;
	logic [AGE_W-1:0]  agg_age;
	logic [CNT_W-1:0]  cfg_size;
	logic [AGE_W-1:0]  cfg_timeout;
	logic [WORD_W-1:0] cfg_vmeta;
	logic [WORD_W-1:0] cfg_fmeta;

	out_rec_t pending_events [$];

	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;
	int unsigned hold_req;
	int unsigned hold_left;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// compare every output beat with the oldest predicted element
	always @(posedge clk) begin
		out_rec_t got;
		out_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.event_kind    = m_tuser;
			got.evt_meta      = m_tdata[63:0];
			got.element_value = m_tdata[127:64];
			got.element_count = m_tdata[133:128];
			got.flush_cause   = m_tdata[135:134];
			got.last          = m_tlast;
			if (pending_events.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected beat: kind %0d meta %h val %h cnt %0d cause %0d last %0d",
						got.event_kind, got.evt_meta, got.element_value,
						got.element_count, got.flush_cause, got.last);
			end else begin
				want = pending_events.pop_front();
				if (got.event_kind !== want.event_kind || got.evt_meta !== want.evt_meta ||
				    got.element_value !== want.element_value ||
				    got.element_count !== want.element_count ||
				    got.flush_cause !== want.flush_cause || got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX) begin
						$display("mismatch exp: kind %0d meta %h val %h cnt %0d cause %0d last %0d",
							want.event_kind, want.evt_meta, want.element_value,
							want.element_count, want.flush_cause, want.last);
						$display("         got: kind %0d meta %h val %h cnt %0d cause %0d last %0d",
							got.event_kind, got.evt_meta, got.element_value,
							got.element_count, got.flush_cause, got.last);
					end
				end
			end
		end
	end

	function automatic int unsigned batch_limit();
		int unsigned s;
		s = cfg_size;
		if (s == 0)
			s = 1;
		if (s > MAX_VECTOR)
			s = MAX_VECTOR;
		return s;
	endfunction

	task automatic close_vector(input logic [1:0] cause);
		int unsigned n;
		out_rec_t r;
		if (!agg_open)
			return;
		n = (agg_fill > MAX_VECTOR) ? MAX_VECTOR : agg_fill;
		for (int unsigned i = 0; i < n; i++) begin
			r.event_kind    = KIND_VEC;
			r.evt_meta      = cfg_vmeta;
			r.element_value = agg_store[i];
			r.element_count = CNT_W'(n);
			r.flush_cause   = cause;
			r.last          = (i + 1 == n);
			pending_events.push_back(r);
		end
		agg_open = 1'b0;
		agg_fill = 0;
		agg_age  = '0;
	endtask

	task automatic predict_item(input in_item_t it);
		out_rec_t r;
		case (it.req_type)
			REQ_FLUSH: close_vector(CAUSE_MARK);
			REQ_TICK: begin
				if (agg_open) begin
					if (agg_age != '1)
						agg_age = agg_age + 1;
					if (agg_age >= cfg_timeout)
						close_vector(CAUSE_TIMEOUT);
				end
			end
			REQ_OBJ: begin
				if (it.start_vector && agg_open)
					close_vector(CAUSE_MARK);
				if (!agg_open && it.buffer_free) begin
					agg_open = 1'b1;
					agg_fill = 0;
				end
				if (agg_open) begin
					if (agg_fill < MAX_VECTOR) begin
						agg_store[agg_fill] = it.object_value;
						agg_fill++;
					end
					if (agg_fill >= batch_limit())
						close_vector(CAUSE_FULL);
				end else begin
					r.event_kind    = KIND_SINGLE;
					r.evt_meta      = cfg_fmeta;
					r.element_value = it.object_value;
					r.element_count = CNT_W'(1);
					r.flush_cause   = CAUSE_FALLBACK;
					r.last          = 1'b1;
					pending_events.push_back(r);
				end
				if (it.call_end) begin
					if (it.end_vector && agg_open)
						close_vector(CAUSE_MARK);
					if (agg_open)
						agg_age = '0;
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t object_item(input logic [WORD_W-1:0] value, input logic sov,
		input logic eov, input logic cend, input logic bfree);
		in_item_t it;
		it.req_type     = REQ_OBJ;
		it.object_value = value;
		it.start_vector = sov;
		it.end_vector   = eov;
		it.call_end     = cend;
		it.buffer_free  = bfree;
		return it;
	endfunction

	// control requests carry random payload bits, which the block must ignore
	function automatic in_item_t control_item(input logic [1:0] req);
		in_item_t it;
		it.req_type     = req;
		it.object_value = rand_word();
		it.start_vector = 1'($urandom_range(1));
		it.end_vector   = 1'($urandom_range(1));
		it.call_end     = 1'($urandom_range(1));
		it.buffer_free  = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int unsigned gap;
		gap = 0;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct && gap < 40)
			gap++;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {5'b0, it.buffer_free, it.end_vector, it.start_vector, it.object_value};
		s_tuser  <= it.req_type;
		s_tlast  <= it.call_end;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_item(it);
	endtask

	// wait until every predicted beat has left and the sequencer has gone quiet
	task automatic settle_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
		settle_block();
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_VSIZE:   cfg_size = value[CNT_W-1:0];
			REG_TIMEOUT: cfg_timeout = value[AGE_W-1:0];
			REG_VMETA:   cfg_vmeta = value;
			REG_FALLMETA: cfg_fmeta = value;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one enqueue call: a run of objects, call_end on the last one
	task automatic send_call(input int unsigned max_len, output int unsigned sent);
		int unsigned len;
		logic        sov;
		logic        eov;
		logic        bfree;
		len = $urandom_range(max_len, 1);
		for (int unsigned i = 0; i < len; i++) begin
			sov   = (i == 0) ? ($urandom_range(99) < 25) : ($urandom_range(99) < 5);
			eov   = (i + 1 == len) ? ($urandom_range(99) < 35) : ($urandom_range(99) < 10);
			bfree = ($urandom_range(99) < 90);
			send_item(object_item(rand_word(), sov, eov, i + 1 == len, bfree));
		end
		sent = len;
	endtask

	task automatic traffic_phase(input int unsigned n_items, input int unsigned max_len);
		int unsigned done;
		int unsigned k;
		int unsigned pick;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_call(max_len, k);
				done += k;
			end else if (pick < 82) begin
				send_item(control_item(REQ_TICK));
				done++;
			end else if (pick < 92) begin
				send_item(control_item(REQ_FLUSH));
				done++;
			end else if (pick < 96) begin
				// unused request code
				send_item(control_item(2'($unsigned(3))));
			end else begin
				send_item(object_item(rand_word(), 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1))));
				done++;
			end
		end
	endtask

	task automatic test_directed_cases();
		write_reg(REG_VSIZE, 64'd3);
		write_reg(REG_TIMEOUT, 64'd2);
		write_reg(REG_VMETA, '1);
		write_reg(REG_FALLMETA, 64'h0123_4567_89ab_cdef);
		send_item(object_item('0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(object_item('1, 1'b0, 1'b0, 1'b1, 1'b1));
		send_item(object_item(64'h8000_0000_0000_0001, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(control_item(REQ_FLUSH));
		send_item(control_item(REQ_TICK));
		send_item(object_item(64'h5555_aaaa_5555_aaaa, 1'b0, 1'b0, 1'b1, 1'b0));
		send_item(object_item(64'haaaa_5555_aaaa_5555, 1'b0, 1'b1, 1'b1, 1'b1));
		send_item(object_item(64'h1, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(object_item(64'h2, 1'b1, 1'b0, 1'b0, 1'b1));
		// end mark without call end is ignored
		send_item(object_item(64'h3, 1'b0, 1'b1, 1'b0, 1'b1));
		send_item(object_item(64'h4, 1'b0, 1'b0, 1'b1, 1'b1));
		send_item(object_item(64'h5, 1'b0, 1'b0, 1'b1, 1'b1));
		send_item(control_item(REQ_TICK));
		send_item(control_item(REQ_TICK));
		send_item(control_item(2'($unsigned(3))));
		send_item(object_item(64'h6, 1'b1, 1'b0, 1'b1, 1'b1));
		send_item(control_item(REQ_FLUSH));
		send_item(object_item(64'h7, 1'b1, 1'b1, 1'b1, 1'b0));
		// vector left open, then size lowered under the fill
		send_item(object_item(64'h8, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(object_item(64'h9, 1'b0, 1'b0, 1'b1, 1'b1));
		write_reg(REG_VSIZE, 64'd1);
		send_item(object_item(64'ha, 1'b0, 1'b0, 1'b0, 1'b1));
	endtask

	task automatic test_size_limits();
		write_reg(REG_VSIZE, 64'd0);
		write_reg(REG_VMETA, '0);
		send_item(object_item(rand_word(), 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(object_item(rand_word(), 1'b0, 1'b0, 1'b1, 1'b1));
		write_reg(REG_VSIZE, 64'd63);
		write_reg(REG_TIMEOUT, 64'hffff_ffff);
		for (int i = 0; i < MAX_VECTOR; i++)
			send_item(object_item(rand_word(), 1'b0, 1'b0, 1'($urandom_range(1)), 1'b1));
		write_reg(REG_VSIZE, 64'd32);
		write_reg(REG_TIMEOUT, 64'd1);
		send_item(object_item(rand_word(), 1'b0, 1'b0, 1'b1, 1'b1));
		send_item(control_item(REQ_TICK));
	endtask

	task automatic test_random_traffic();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		write_reg(REG_VSIZE, 64'd4);
		write_reg(REG_TIMEOUT, 64'd3);
		write_reg(REG_VMETA, rand_word());
		write_reg(REG_FALLMETA, rand_word());
		traffic_phase(60, 6);

		src_idle_pct = 65;
		snk_stall_pct = 0;
		write_reg(REG_VSIZE, 64'd1);
		write_reg(REG_TIMEOUT, 64'd1);
		write_reg(REG_FALLMETA, '1);
		traffic_phase(60, 4);

		src_idle_pct = 0;
		snk_stall_pct = 65;
		write_reg(REG_VSIZE, 64'd7);
		write_reg(REG_TIMEOUT, 64'd5);
		write_reg(REG_VMETA, rand_word());
		traffic_phase(60, 8);

		src_idle_pct = 20;
		snk_stall_pct = 20;
		write_reg(REG_VSIZE, 64'd32);
		write_reg(REG_TIMEOUT, 64'hffff_ffff);
		write_reg(REG_VMETA, '1);
		write_reg(REG_FALLMETA, '0);
		traffic_phase(65, 10);
	endtask

	task automatic test_backpressure();
		int unsigned k;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		write_reg(REG_VSIZE, 64'd8);
		write_reg(REG_TIMEOUT, 64'd4);
		@(negedge clk);
		hold_req = 400;
		// sender keeps offering while the output is held off
		for (int i = 0; i < 6; i++)
			send_call(8, k);
		send_item(control_item(REQ_FLUSH));
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		m_tready = 1'b0;
		hold_req = 0;
		hold_left = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		mismatch_count = 0;
		cycle_count = 0;
		agg_fill = 0;
		agg_open = 1'b0;
		agg_age = '0;
		cfg_size = VSIZE_RST;
		cfg_timeout = TIMEOUT_RST;
		cfg_vmeta = '0;
		cfg_fmeta = '0;
		for (int i = 0; i < MAX_VECTOR; i++)
			agg_store[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_size_limits();
		test_random_traffic();
		test_backpressure();

		settle_block();
		if (mismatch_count == 0 && pending_events.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/evagg_pkg.sv
hw/rtl/evagg_cfg.sv
hw/rtl/evagg_ctrl.sv
hw/rtl/evagg_outq.sv
hw/rtl/event_vector_aggregator_top.sv
tb/tb_event_vector_aggregator_top.sv
